>>> rtl/core/kped_pkg.sv
// Shared types and constants for the key press event detector.
package kped_pkg;

	// Event codes carried on the result channel
	typedef enum logic [2:0] {
		EV_PRESSED     = 3'd0,
		EV_REPEAT      = 3'd1,
		EV_LONG        = 3'd2,
		EV_SHORT_CLICK = 3'd3,
		EV_CLICK       = 3'd4,
		EV_RELEASED    = 3'd5
	} event_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LONG_PRESS    = 2'd0,
		REG_REPEAT_PERIOD = 2'd1
	} reg_idx_t;

	localparam logic [31:0] LONG_PRESS_DEFAULT    = 32'd500;
	localparam logic [31:0] REPEAT_PERIOD_DEFAULT = 32'd200;

	// One result entry
	typedef struct packed {
		event_t code;
		logic   last;
	} result_t;

	// Results of evaluating one sample: count and up to two entries
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} eval_out_t;

endpackage

>>> rtl/core/kped_if.sv
// Handshake channel interfaces: key samples, events and register writes.
interface kped_in_if;
	logic        valid;
	logic        ready;
	logic        key_level;
	logic [31:0] now_ms;

	modport source (output valid, output key_level, output now_ms, input ready);
	modport sink   (input valid, input key_level, input now_ms, output ready);
endinterface

interface kped_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic       last_event;

	modport source (output valid, output event_code, output last_event, input ready);
	modport sink   (input valid, input event_code, input last_event, output ready);
endinterface

interface kped_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/kped_eval.sv
// Debounce, hold timing and event classification with its state registers.
module kped_eval
	import kped_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	kped_cfg_if.sink         cfg,
	input  logic             level_s1,
	input  logic [31:0]      now_s1,
	input  logic             advance,
	output eval_out_t        res
);

	logic [31:0] long_press_q;
	logic [31:0] repeat_period_q;
	logic        prev_sample_q;
	logic        held_q;
	logic [31:0] press_start_q;
	logic [31:0] last_repeat_q;
	logic        long_reported_q;

	logic        unstable;
	logic        rising;
	logic [31:0] hold;
	logic [31:0] since_repeat;
	logic        rep_hit;
	logic        long_hit;

	assign cfg.ready = 1'b1;

	// Configuration registers; zero loads the default
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q    <= LONG_PRESS_DEFAULT;
			repeat_period_q <= REPEAT_PERIOD_DEFAULT;
		end else if (cfg.valid) begin
			if (cfg.index == REG_LONG_PRESS) begin
				long_press_q <= (cfg.data != 32'd0) ? cfg.data : LONG_PRESS_DEFAULT;
			end else if (cfg.index == REG_REPEAT_PERIOD) begin
				repeat_period_q <= (cfg.data != 32'd0) ? cfg.data : REPEAT_PERIOD_DEFAULT;
			end
		end
	end

	// Timing terms
	assign unstable     = (level_s1 != prev_sample_q);
	assign rising       = level_s1 && !held_q;
	assign hold         = now_s1 - press_start_q;
	assign since_repeat = hold - last_repeat_q;
	assign rep_hit      = (since_repeat >= repeat_period_q);
	assign long_hit     = (hold >= long_press_q) && !long_reported_q;

	// Event classification
	always_comb begin
		res.cnt     = 2'd0;
		res.r0.code = EV_PRESSED;
		res.r0.last = 1'b1;
		res.r1.code = EV_RELEASED;
		res.r1.last = 1'b1;
		if (!unstable) begin
			if (rising) begin
				res.cnt     = 2'd1;
				res.r0.code = EV_PRESSED;
			end else if (level_s1) begin
				// repeat goes ahead of long press
				if (rep_hit && long_hit) begin
					res.cnt     = 2'd2;
					res.r0.code = EV_REPEAT;
					res.r0.last = 1'b0;
					res.r1.code = EV_LONG;
				end else if (rep_hit) begin
					res.cnt     = 2'd1;
					res.r0.code = EV_REPEAT;
				end else if (long_hit) begin
					res.cnt     = 2'd1;
					res.r0.code = EV_LONG;
				end
			end else if (held_q) begin
				res.cnt     = 2'd2;
				res.r0.code = (hold < long_press_q) ? EV_SHORT_CLICK : EV_CLICK;
				res.r0.last = 1'b0;
				res.r1.code = EV_RELEASED;
			end
		end
	end

	// Key state update when the sample leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q   <= 1'b0;
			held_q          <= 1'b0;
			press_start_q   <= 32'd0;
			last_repeat_q   <= 32'd0;
			long_reported_q <= 1'b0;
		end else if (advance) begin
			if (unstable) begin
				prev_sample_q <= level_s1;
			end else begin
				held_q <= level_s1;
				if (rising) begin
					press_start_q <= now_s1;
					last_repeat_q <= 32'd0;
				end else if (level_s1) begin
					if (rep_hit) begin
						last_repeat_q <= hold;
					end
					if (long_hit) begin
						long_reported_q <= 1'b1;
					end
				end else if (held_q) begin
					press_start_q   <= 32'd0;
					last_repeat_q   <= 32'd0;
					long_reported_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/core/kped_outq.sv
// Four-entry result queue taking up to two events per cycle.
module kped_outq
	import kped_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_cnt,
	input  result_t          r0,
	input  result_t          r1,
	output logic             space_ok,
	kped_out_if.source       evt
);

	result_t     mem_q [4];
	logic [1:0]  wptr_q;
	logic [1:0]  rptr_q;
	logic [2:0]  count_q;
	logic        pop;
	logic [1:0]  wptr_nxt;

	assign pop            = evt.valid && evt.ready;
	assign evt.valid      = (count_q != 3'd0);
	assign evt.event_code = mem_q[rptr_q].code;
	assign evt.last_event = mem_q[rptr_q].last;
	// room for a full two-event burst
	assign space_ok       = (count_q <= 3'd2);
	assign wptr_nxt       = wptr_q + 2'd1;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wptr_q] <= r0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wptr_nxt] <= r1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 2'd0;
			rptr_q  <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wptr_q  <= wptr_q + push_cnt;
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push_cnt} - {2'b00, pop};
		end
	end

endmodule

>>> rtl/core/key_press_event_detector.sv
// Top level of the key press event detector.
//
//   port    dir   carries                       request
//   key_in  sink  key_level, now_ms             one poll sample
//   evt_out src   event_code, last_event        one event
//   cfg     sink  index, data                   one register write
//
// A sample is taken into the input register, evaluated combinationally and its
// zero to two events land in a four-entry result queue. One sample per cycle
// is taken while the queue has room for two events; the event port drains
// one event per cycle when ready; sustained rate is set by events per sample.
// Register writes are taken every cycle. Reset clears key state, queue and
// registers to their defaults. A stalled event port holds events in the queue.
module key_press_event_detector
	import kped_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	kped_in_if.sink     key_in,
	kped_out_if.source  evt_out,
	kped_cfg_if.sink    cfg
);

	logic        valid_s1;
	logic        level_s1;
	logic [31:0] now_s1;
	logic        space_ok;
	logic        advance;
	logic        take;
	eval_out_t   res;
	logic [1:0]  push_cnt;

	assign advance      = valid_s1 && space_ok;
	assign key_in.ready = !valid_s1 || space_ok;
	assign take         = key_in.valid && key_in.ready;
	assign push_cnt     = advance ? res.cnt : 2'd0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			level_s1 <= key_in.key_level;
			now_s1   <= key_in.now_ms;
		end
	end

	kped_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.level_s1 (level_s1),
		.now_s1   (now_s1),
		.advance  (advance),
		.res      (res)
	);

	kped_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.r0       (res.r0),
		.r1       (res.r1),
		.space_ok (space_ok),
		.evt      (evt_out)
	);

endmodule
